// ----- hw/rtl/rvs_pkg.sv -----
// ----------------------------------------------------------------------------
// rvs_pkg
// shared types and constants for the rv64 subset core
// ----------------------------------------------------------------------------
package rvs_pkg;

    // default sizes, as log2 of the word counts
    localparam int DATA_AW_DEF  = 12;
    localparam int INSTR_AW_DEF = 15;

    // fixed widths of the fetch index result field and the decoded immediate
    localparam int FETCH_W = 15;
    localparam int IMM_W   = 21;

    // opcodes, bits [6:0] of the instruction
    localparam logic [6:0] OPC_ADD  = 7'h33;
    localparam logic [6:0] OPC_ADDI = 7'h13;
    localparam logic [6:0] OPC_JAL  = 7'h6f;
    localparam logic [6:0] OPC_JALR = 7'h67;
    localparam logic [6:0] OPC_BEQ  = 7'h63;
    localparam logic [6:0] OPC_LD   = 7'h03;
    localparam logic [6:0] OPC_SD   = 7'h23;

    // register watched for the t1 flag and the value it is compared with
    localparam logic [4:0]  WATCH_REG   = 5'd9;
    localparam logic [63:0] WATCH_VALUE = 64'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_HALT,
        OP_ADD,
        OP_ADDI,
        OP_JAL,
        OP_JALR,
        OP_BEQ,
        OP_LD,
        OP_SD
    } op_t;

    // decoded instruction
    typedef struct packed {
        op_t                     op;
        logic [4:0]              rs1;
        logic [4:0]              rs2;
        logic [4:0]              rd;
        logic signed [IMM_W-1:0] imm;
    } uop_t;

    // head of the queue, front to back
    typedef struct packed {
        logic valid;
        uop_t uop;
    } q_head_t;

    // back to front control
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    // one result item
    typedef struct packed {
        logic              t1_equals_ten;
        logic signed [63:0] reg_value;
        logic [4:0]        reg_number;
        logic              reg_write;
        logic              halted;
        logic [FETCH_W-1:0] fetch_index;
    } result_t;

endpackage

// ----- hw/rtl/rvs_front.sv -----
// ----------------------------------------------------------------------------
// rvs_front
// input transfer, instruction decode and a two-entry queue toward the back
// ----------------------------------------------------------------------------
module rvs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_word,
    output rvs_pkg::q_head_t    head,
    input  rvs_pkg::back_ctl_t  ctl
);

    rvs_pkg::uop_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic          pop;
    rvs_pkg::uop_t dec;

    // decode: opcode selects the class, immediate by format
    always_comb
    begin
        dec     = '0;
        dec.rs1 = in_word[19:15];
        dec.rs2 = in_word[24:20];
        dec.rd  = in_word[11:7];
        dec.op  = rvs_pkg::OP_NOP;
        case (in_word[6:0])
            rvs_pkg::OPC_ADD:  dec.op = rvs_pkg::OP_ADD;
            rvs_pkg::OPC_ADDI: dec.op = rvs_pkg::OP_ADDI;
            rvs_pkg::OPC_JAL:  dec.op = rvs_pkg::OP_JAL;
            rvs_pkg::OPC_JALR: dec.op = rvs_pkg::OP_JALR;
            rvs_pkg::OPC_BEQ:  dec.op = rvs_pkg::OP_BEQ;
            rvs_pkg::OPC_LD:   dec.op = rvs_pkg::OP_LD;
            rvs_pkg::OPC_SD:   dec.op = rvs_pkg::OP_SD;
            default:           dec.op = rvs_pkg::OP_NOP;
        endcase
        if (in_word == 32'd0)
        begin
            dec.op = rvs_pkg::OP_HALT;
        end
        case (dec.op)
            rvs_pkg::OP_SD:
                dec.imm = {{9{in_word[31]}}, in_word[31:25], in_word[11:7]};
            rvs_pkg::OP_BEQ:
                dec.imm = {{8{in_word[31]}}, in_word[31], in_word[7],
                           in_word[30:25], in_word[11:8], 1'b0};
            rvs_pkg::OP_JAL:
                dec.imm = {in_word[31], in_word[19:12], in_word[20],
                           in_word[30:21], 1'b0};
            default:
                dec.imm = {{9{in_word[31]}}, in_word[31:20]};
        endcase
    end

    assign in_ready   = (count_reg != 2'd2) && !ctl.clearing;
    assign push       = in_valid && in_ready;
    assign pop        = ctl.pop;
    assign head.valid = (count_reg != 2'd0);
    assign head.uop   = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ----- hw/rtl/rvs_back.sv -----
// ----------------------------------------------------------------------------
// rvs_back
// execute pipeline: register read, execute and memory, write back, result
// ----------------------------------------------------------------------------
module rvs_back
#(
    parameter int DATA_AW  = rvs_pkg::DATA_AW_DEF,
    parameter int INSTR_AW = rvs_pkg::INSTR_AW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rvs_pkg::q_head_t    head,
    output rvs_pkg::back_ctl_t  ctl,
    output logic                res_valid,
    input  logic                res_ready,
    output rvs_pkg::result_t    res
);

    localparam int DATA_WORDS = 2 ** DATA_AW;

    // storage
    logic [63:0]        rf_mem [32];
    logic [31:0]        rf_ok_reg;
    logic [63:0]        dm_mem [DATA_WORDS];

    // clearing pass
    logic               clr_busy_reg;
    logic [DATA_AW-1:0] clr_addr_reg;

    // pipeline control
    logic               adv;
    logic               pop;
    logic               e2_valid_reg;
    logic               e3_valid_reg;
    logic               out_valid_reg;

    // register read stage
    rvs_pkg::uop_t      e2_uop_reg;
    logic [63:0]        rd1_data_reg;
    logic [63:0]        rd2_data_reg;
    logic               rd1_ok_reg;
    logic               rd2_ok_reg;
    logic [INSTR_AW-1:0] pc_reg;

    // execute
    logic [63:0]        opa;
    logic [63:0]        opb;
    logic [63:0]        imm64;
    logic [63:0]        sum;
    logic [INSTR_AW-1:0] next_seq;
    logic [INSTR_AW-1:0] rel_target;
    logic [INSTR_AW-1:0] next_pc;
    logic [63:0]        ex_val;
    logic               ex_wr;
    logic               ex_ld;
    logic               ex_sd;
    logic [DATA_AW-1:0] dm_idx;

    // write back stage
    logic               e3_wr_reg;
    logic               e3_ld_reg;
    logic               e3_halt_reg;
    logic [4:0]         e3_rd_reg;
    logic [63:0]        e3_val_reg;
    logic [INSTR_AW-1:0] e3_fetch_reg;
    logic [63:0]        dm_rdata_reg;
    logic [63:0]        e3_value;
    logic               wb_en;
    logic               t1_next;

    // last completed register write, for forwarding
    logic               lw_valid_reg;
    logic [4:0]         lw_rd_reg;
    logic [63:0]        lw_val_reg;

    logic               t1_flag_reg;
    rvs_pkg::result_t   out_reg;

    assign adv          = !out_valid_reg || res_ready;
    assign pop          = adv && head.valid && !clr_busy_reg;
    assign ctl.pop      = pop;
    assign ctl.clearing = clr_busy_reg;
    assign res_valid    = out_valid_reg;
    assign res          = out_reg;

    assign e3_value = e3_ld_reg ? dm_rdata_reg : e3_val_reg;
    assign wb_en    = adv && e3_valid_reg && e3_wr_reg;

    // operands, newest write wins
    always_comb
    begin
        if (e3_valid_reg && e3_wr_reg && (e3_rd_reg == e2_uop_reg.rs1))
        begin
            opa = e3_value;
        end
        else if (lw_valid_reg && (lw_rd_reg == e2_uop_reg.rs1))
        begin
            opa = lw_val_reg;
        end
        else
        begin
            opa = rd1_ok_reg ? rd1_data_reg : 64'd0;
        end

        if (e3_valid_reg && e3_wr_reg && (e3_rd_reg == e2_uop_reg.rs2))
        begin
            opb = e3_value;
        end
        else if (lw_valid_reg && (lw_rd_reg == e2_uop_reg.rs2))
        begin
            opb = lw_val_reg;
        end
        else
        begin
            opb = rd2_ok_reg ? rd2_data_reg : 64'd0;
        end
    end

    assign imm64      = 64'(e2_uop_reg.imm);
    assign sum        = opa + ((e2_uop_reg.op == rvs_pkg::OP_ADD) ? opb : imm64);
    assign next_seq   = pc_reg + INSTR_AW'(1);
    // pc*4 has clear low bits, so the word target is pc plus the word part of imm
    assign rel_target = pc_reg + imm64[INSTR_AW+1:2];
    assign dm_idx     = sum[DATA_AW+2:3];

    always_comb
    begin
        next_pc = next_seq;
        ex_val  = sum;
        ex_wr   = 1'b0;
        ex_ld   = 1'b0;
        ex_sd   = 1'b0;
        case (e2_uop_reg.op)
            rvs_pkg::OP_HALT:
            begin
                next_pc = pc_reg;
            end
            rvs_pkg::OP_ADD,
            rvs_pkg::OP_ADDI:
            begin
                ex_wr = 1'b1;
            end
            rvs_pkg::OP_JAL:
            begin
                ex_val  = {62'(next_seq), 2'b00};
                ex_wr   = 1'b1;
                next_pc = rel_target;
            end
            rvs_pkg::OP_JALR:
            begin
                ex_val  = {62'(next_seq), 2'b00};
                ex_wr   = 1'b1;
                next_pc = sum[INSTR_AW+1:2];
            end
            rvs_pkg::OP_BEQ:
            begin
                if (opa == opb)
                begin
                    next_pc = rel_target;
                end
            end
            rvs_pkg::OP_LD:
            begin
                ex_wr = 1'b1;
                ex_ld = 1'b1;
            end
            rvs_pkg::OP_SD:
            begin
                ex_sd = 1'b1;
            end
            default:
            begin
                next_pc = next_seq;
            end
        endcase
        if (e2_uop_reg.rd == 5'd0)
        begin
            ex_wr = 1'b0;
        end
    end

    assign t1_next = (e3_wr_reg && (e3_rd_reg == rvs_pkg::WATCH_REG))
                   ? (e3_value == rvs_pkg::WATCH_VALUE) : t1_flag_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            rf_ok_reg     <= '0;
            lw_valid_reg  <= 1'b0;
            t1_flag_reg   <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + DATA_AW'(1);
                if (&clr_addr_reg)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                e2_valid_reg  <= pop;
                e3_valid_reg  <= e2_valid_reg;
                out_valid_reg <= e3_valid_reg;
                if (e2_valid_reg)
                begin
                    pc_reg <= next_pc;
                end
                if (e3_valid_reg)
                begin
                    t1_flag_reg <= t1_next;
                end
            end
            if (wb_en)
            begin
                rf_ok_reg[e3_rd_reg] <= 1'b1;
                lw_valid_reg         <= 1'b1;
            end
        end
    end

    // register file and pipeline payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e2_uop_reg   <= head.uop;
            rd1_data_reg <= rf_mem[head.uop.rs1];
            rd2_data_reg <= rf_mem[head.uop.rs2];
            rd1_ok_reg   <= rf_ok_reg[head.uop.rs1];
            rd2_ok_reg   <= rf_ok_reg[head.uop.rs2];
        end
        if (wb_en)
        begin
            rf_mem[e3_rd_reg] <= e3_value;
            lw_rd_reg         <= e3_rd_reg;
            lw_val_reg        <= e3_value;
        end
        if (adv && e2_valid_reg)
        begin
            e3_wr_reg    <= ex_wr;
            e3_ld_reg    <= ex_ld;
            e3_halt_reg  <= (e2_uop_reg.op == rvs_pkg::OP_HALT);
            e3_rd_reg    <= e2_uop_reg.rd;
            e3_val_reg   <= ex_val;
            e3_fetch_reg <= next_pc;
        end
        if (adv && e3_valid_reg)
        begin
            out_reg.fetch_index   <= rvs_pkg::FETCH_W'(e3_fetch_reg);
            out_reg.halted        <= e3_halt_reg;
            out_reg.reg_write     <= e3_wr_reg;
            out_reg.reg_number    <= e3_wr_reg ? e3_rd_reg : 5'd0;
            out_reg.reg_value     <= e3_wr_reg ? e3_value : 64'd0;
            out_reg.t1_equals_ten <= t1_next;
        end
    end

    // data store: one write port shared by the clearing pass and sd
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            dm_mem[clr_addr_reg] <= 64'd0;
        end
        else if (adv && e2_valid_reg && ex_sd)
        begin
            dm_mem[dm_idx] <= opb;
        end
        if (adv && e2_valid_reg && ex_ld)
        begin
            dm_rdata_reg <= dm_mem[dm_idx];
        end
    end

endmodule

// ----- hw/rtl/rv64_subset_core_step.sv -----
// ----------------------------------------------------------------------------
// rv64_subset_core_step
// rv64i subset core (add, addi, jal, jalr, beq, ld, sd), one result per instruction
// ----------------------------------------------------------------------------
// Each instruction word sent on the slave stream is executed and gives one
// result on the master stream: the next fetch index, the halt flag, the
// register write (if any) and whether x9 holds ten. The sender is expected to
// fetch each word at the index the previous result reported (0 after reset).
// After reset the data store is swept to zero, one doubleword per cycle, over
// all 2**DATA_AW doublewords (4096 at the default size); s_axis_tready stays
// low until the sweep is done. After that one instruction is taken per cycle,
// sustained, as long as results are taken; each instruction passes through the
// decode queue, register read, execute and memory, and write back registers
// before its result is presented. The back end is one in-order pipeline with
// operand forwarding from write back, so the single data store port and the
// register file set the one-per-cycle figure. A two-entry queue between decode
// and execute lets the input side keep transferring while a result waits on the
// output register.
// ----------------------------------------------------------------------------
module rv64_subset_core_step
#(
    parameter int DATA_AW  = rvs_pkg::DATA_AW_DEF,   // log2 of data store doublewords
    parameter int INSTR_AW = rvs_pkg::INSTR_AW_DEF   // log2 of instruction store words
)
(
    input  logic         clk,
    input  logic         rst_n,
    // instruction stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,    // [31:0] instr_word
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata     // [14:0] fetch_index, [15] halted,
                                          // [16] reg_write, [21:17] reg_number,
                                          // [85:22] reg_value, [86] t1_equals_ten,
                                          // [87] zero
);

    rvs_pkg::q_head_t   head;
    rvs_pkg::back_ctl_t ctl;
    rvs_pkg::result_t   res;

    // decode and queue
    rvs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (s_axis_tdata),
        .head     (head),
        .ctl      (ctl)
    );

    // execute pipeline with register file and data store
    rvs_back
    #(
        .DATA_AW  (DATA_AW),
        .INSTR_AW (INSTR_AW)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .ctl       (ctl),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // pack the result below a zero top bit, last struct field in the lowest bits
    assign m_axis_tdata = {1'b0, res};

endmodule
